// File: rtl/core/wpss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpss_pkg: shared types and constants of the weighted prefix-sum sampler
// Tree geometry, field widths and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package wpss_pkg;

   localparam int ENTRIES  = 1024;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = IDX_W + 1;
   localparam int WALK_W   = IDX_W + 2;
   localparam int SUM_W    = 48;
   localparam int DELTA_W  = 40;
   localparam int TARGET_W = 47;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 3;

   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   localparam logic REG_ENTRIES_IN_USE = 1'b0;

   typedef struct packed {
      logic clear;
      logic load_add;
      logic load_srch;
      logic rd_add;
      logic rd_srch;
      logic upd;
      logic step;
      logic cmp;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic delta_zero;
      logic walk_ok;
      logic bit_zero;
      logic next_ok;
   } sts_type;

endpackage

// File: rtl/core/weighted_prefix_sum_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_prefix_sum_sampler: binary indexed tree for weighted selection
// An add request adds a signed delta to one entry and its covering tree
// nodes; a search request descends the tree to the largest prefix whose sum
// stays below the target. Every request returns one response with the
// running weight total.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 1024-entry node memory to zero, one entry
// per cycle, and keeps req_stall high until the sweep ends; csr writes are
// taken during the sweep. Requests are then handled one at a time through a
// single-port node memory with a registered read. An add visits k tree nodes
// (k is at most 11, zero for a zero delta or an entry beyond entries_in_use);
// a search steps through all 11 index bits and reads r nodes (r at most 11).
// A finished response sits in an output register, and the next request is
// taken while it waits. entries_in_use of 0 acts as 1, above 1024 as 1024.
// ----------------------------------------------------------------------------
module weighted_prefix_sum_sampler import wpss_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_func,
   input  logic [IDX_W-1:0]          req_entry_index,
   input  logic signed [DELTA_W-1:0] req_weight_delta,
   input  logic [TARGET_W-1:0]       req_search_target,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [IDX_W-1:0]          rsp_selected_index,
   output logic signed [SUM_W-1:0]   rsp_weight_total,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_AW-1:0]         csr_paddr,
   input  logic [CSR_DW-1:0]         csr_pwdata,
   output logic [CSR_DW-1:0]         csr_prdata,
   output logic                      csr_pready
);

   logic [CNT_W-1:0] entries_ff;
   logic [CNT_W-1:0] active_cnt;
   logic             csr_wr;
   cmd_type          cmd;
   sts_type          sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_AW-1] == REG_ENTRIES_IN_USE)
                       ? CSR_DW'(entries_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= CNT_W'(ENTRIES);
      end else if (csr_wr && (csr_paddr[CSR_AW-1] == REG_ENTRIES_IN_USE)) begin
         entries_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   always_comb begin
      if (entries_ff == '0) begin
         active_cnt = CNT_W'(1);
      end else if (entries_ff > CNT_W'(ENTRIES)) begin
         active_cnt = CNT_W'(ENTRIES);
      end else begin
         active_cnt = entries_ff;
      end
   end

   wpss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   wpss_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .active_cnt         (active_cnt),
      .req_entry_index    (req_entry_index),
      .req_weight_delta   (req_weight_delta),
      .req_search_target  (req_search_target),
      .rsp_selected_index (rsp_selected_index),
      .rsp_weight_total   (rsp_weight_total)
   );

   a_reset_holds_off: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken right after reset");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken before first completed");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response raised without a request in progress");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.load_add, cmd.load_srch, cmd.rd_add, cmd.rd_srch,
                cmd.upd, cmd.step, cmd.cmp, cmd.out_load}))
      else $error("conflicting datapath commands");

endmodule

// File: rtl/core/wpss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpss_dp: tree store and arithmetic of the weighted prefix-sum sampler
// Holds the node memory, the add walk, the search descent, the running
// total and the response payload register.
// ----------------------------------------------------------------------------
module wpss_dp import wpss_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   input  logic [CNT_W-1:0]           active_cnt,
   input  logic [IDX_W-1:0]           req_entry_index,
   input  logic signed [DELTA_W-1:0]  req_weight_delta,
   input  logic [TARGET_W-1:0]        req_search_target,
   output logic [IDX_W-1:0]           rsp_selected_index,
   output logic signed [SUM_W-1:0]    rsp_weight_total
);

   logic [SUM_W-1:0]    mem [ENTRIES];
   logic [SUM_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]    clr_addr_ff;
   logic [WALK_W-1:0]   walk_ff;
   logic [SUM_W-1:0]    delta_ff;
   logic [TARGET_W-1:0] target_ff;
   logic [CNT_W-1:0]    idx_ff;
   logic [SUM_W-1:0]    acc_ff;
   logic [CNT_W-1:0]    bit_ff;
   logic [SUM_W-1:0]    total_ff;
   logic [IDX_W-1:0]    sel_ff;
   logic [SUM_W-1:0]    total_out_ff;

   logic [SUM_W-1:0]    delta_ext;
   logic [CNT_W-1:0]    next_idx;
   logic [WALK_W-1:0]   walk_m1;
   logic [CNT_W-1:0]    next_m1;
   logic [WALK_W-1:0]   lowbit;
   logic [SUM_W-1:0]    node_sum;
   logic [SUM_W-1:0]    srch_sum;
   logic                take;
   logic [CNT_W-1:0]    sel_full;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   logic                wr_en;
   logic [SUM_W-1:0]    wr_data;

   assign delta_ext = {{(SUM_W-DELTA_W){req_weight_delta[DELTA_W-1]}}, req_weight_delta};
   assign next_idx  = idx_ff | bit_ff;
   assign walk_m1   = walk_ff - WALK_W'(1);
   assign next_m1   = next_idx - CNT_W'(1);
   assign lowbit    = walk_ff & (~walk_ff + WALK_W'(1));
   assign node_sum  = rd_data_ff + delta_ff;
   assign srch_sum  = acc_ff + rd_data_ff;
   assign take      = $signed(srch_sum) < $signed({1'b0, target_ff});
   assign sel_full  = (idx_ff >= active_cnt) ? (active_cnt - CNT_W'(1)) : idx_ff;

   assign rd_addr = cmd.rd_srch ? next_m1[IDX_W-1:0] : walk_m1[IDX_W-1:0];
   assign wr_addr = cmd.clear ? clr_addr_ff : walk_m1[IDX_W-1:0];
   assign wr_en   = cmd.clear | cmd.upd;
   assign wr_data = cmd.clear ? '0 : node_sum;

   assign sts.clr_last   = (clr_addr_ff == IDX_W'(ENTRIES - 1));
   assign sts.delta_zero = (delta_ff == '0);
   assign sts.walk_ok    = (walk_ff <= {{(WALK_W-CNT_W){1'b0}}, active_cnt});
   assign sts.bit_zero   = (bit_ff == '0);
   assign sts.next_ok    = (next_idx <= active_cnt);

   assign rsp_selected_index = sel_ff;
   assign rsp_weight_total   = $signed(total_out_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_add || cmd.rd_srch) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         total_ff    <= '0;
      end else begin
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + IDX_W'(1);
         end
         if (cmd.load_add) begin
            total_ff <= total_ff + delta_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_add) begin
         walk_ff  <= WALK_W'(req_entry_index) + WALK_W'(1);
         delta_ff <= delta_ext;
         idx_ff   <= '0;
      end else if (cmd.load_srch) begin
         target_ff <= req_search_target;
         idx_ff    <= '0;
         acc_ff    <= '0;
         bit_ff    <= {1'b1, {(CNT_W-1){1'b0}}};
      end else if (cmd.upd) begin
         walk_ff <= walk_ff + lowbit;
      end else if (cmd.step) begin
         bit_ff <= bit_ff >> 1;
      end else if (cmd.cmp) begin
         if (take) begin
            idx_ff <= next_idx;
            acc_ff <= srch_sum;
         end
         bit_ff <= bit_ff >> 1;
      end
      if (cmd.out_load) begin
         sel_ff       <= sel_full[IDX_W-1:0];
         total_out_ff <= total_ff;
      end
   end

endmodule

// File: rtl/core/wpss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpss_ctrl: sequencer of the weighted prefix-sum sampler
// Runs the clearing pass, the add walk and the search descent, and owns the
// request and response handshakes.
// ----------------------------------------------------------------------------
module wpss_ctrl import wpss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic    req_func,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_SEARCH) begin
                  cmd.load_srch = 1'b1;
                  state_in      = ST_SRCH_RD;
               end else begin
                  cmd.load_add = 1'b1;
                  state_in     = ST_ADD_RD;
               end
            end
         end
         ST_ADD_RD: begin
            if (sts.delta_zero || !sts.walk_ok) begin
               state_in = ST_DONE;
            end else begin
               cmd.rd_add = 1'b1;
               state_in   = ST_ADD_WR;
            end
         end
         ST_ADD_WR: begin
            cmd.upd  = 1'b1;
            state_in = ST_ADD_RD;
         end
         ST_SRCH_RD: begin
            if (sts.bit_zero) begin
               state_in = ST_DONE;
            end else if (sts.next_ok) begin
               cmd.rd_srch = 1'b1;
               state_in    = ST_SRCH_CMP;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_SRCH_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_SRCH_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
